// ===== design/multichannel_button_debounce_to_notes_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce block
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_BUTTON_DEBOUNCE_TO_NOTES_ASSERT_SVH
`define MULTICHANNEL_BUTTON_DEBOUNCE_TO_NOTES_ASSERT_SVH

// Same-cycle implication
`define MBDN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbdn same-cycle check failed");

// Next-cycle implication
`define MBDN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbdn next-cycle check failed");

`endif

// ===== design/mbdn_pkg.sv =====
// ----------------------------------------------------------------------------
// mbdn_pkg
// Types, register codes and reset values for the button debounce block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbdn_pkg;

  localparam int MAX_CHANNELS_DEF = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_MS     = 4'd0,
    REG_BASE_NOTE       = 4'd1,
    REG_MIDI_CHANNEL    = 4'd2,
    REG_ACTIVE_CHANNELS = 4'd3
  } cfg_reg_e;

  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [6:0]  BASE_NOTE_RST = 7'd36;
  localparam logic [3:0]  MIDI_CHANNEL_RST = 4'd0;
  localparam logic [4:0]  ACTIVE_RST = 5'd16;

  localparam logic [6:0] VEL_PRESS   = 7'd127;
  localparam logic [6:0] VEL_RELEASE = 7'd0;
  localparam logic       LEVEL_LOW   = 1'b0;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [6:0]  base_note;
    logic [3:0]  midi_channel;
    logic [4:0]  active_channels;
  } cfg_t;

  // Decision for the word in the input register
  typedef struct packed {
    logic       fire;
    logic [7:0] note;
    logic [6:0] velocity;
  } dec_t;

endpackage

// ===== design/mbdn_cfg.sv =====
// ----------------------------------------------------------------------------
// mbdn_cfg
// Configuration register file, written one register per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbdn_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbdn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbdn_pkg::CFG_DATA_W-1:0] cfg_data,
  output mbdn_pkg::cfg_t                cfg
);
  import mbdn_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode the write; unknown indexes change nothing
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_DEBOUNCE_MS:     cfg_nxt.debounce_ms     = cfg_data;
        REG_BASE_NOTE:       cfg_nxt.base_note       = cfg_data[6:0];
        REG_MIDI_CHANNEL:    cfg_nxt.midi_channel    = cfg_data[3:0];
        REG_ACTIVE_CHANNELS: cfg_nxt.active_channels = cfg_data[4:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= DEBOUNCE_RST;
      cfg_r.base_note       <= BASE_NOTE_RST;
      cfg_r.midi_channel    <= MIDI_CHANNEL_RST;
      cfg_r.active_channels <= ACTIVE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/mbdn_chan.sv =====
// ----------------------------------------------------------------------------
// mbdn_chan
// Per-channel level and change-time registers with the debounce decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbdn_chan #(
  parameter int MAX_CHANNELS = mbdn_pkg::MAX_CHANNELS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mbdn_pkg::cfg_t cfg,
  input  logic           s1_valid,
  input  logic [3:0]     s1_chan_index,
  input  logic           s1_level,
  input  logic [31:0]    s1_now_ms,
  input  logic           advance,
  output mbdn_pkg::dec_t dec
);
  import mbdn_pkg::*;

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [4:0] MAX_CH = 5'(MAX_CHANNELS);

  logic [MAX_CHANNELS-1:0] level_r;
  logic [31:0]             change_r [MAX_CHANNELS];

  logic [4:0]       limit;
  logic             in_range;
  logic [IDX_W-1:0] idx;
  logic [31:0]      elapsed;
  logic             fire;

  // Clamp the channel count and drop out-of-range samples
  assign limit    = (cfg.active_channels > MAX_CH) ? MAX_CH : cfg.active_channels;
  assign in_range = ({1'b0, s1_chan_index} < limit);
  assign idx      = IDX_W'(s1_chan_index);

  // Elapsed time wraps modulo 2^32
  assign elapsed = s1_now_ms - change_r[idx];
  assign fire    = s1_valid && in_range && (elapsed > {16'd0, cfg.debounce_ms}) &&
                   (level_r[idx] != s1_level);

  assign dec.fire     = fire;
  assign dec.note     = {1'b0, cfg.base_note} + {4'd0, s1_chan_index};
  assign dec.velocity = (s1_level == LEVEL_LOW) ? VEL_PRESS : VEL_RELEASE;

  // Store the new level and time on an accepted change
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        change_r[k] <= 32'd0;
      end
    end else if (advance && fire) begin
      level_r[idx]  <= s1_level;
      change_r[idx] <= s1_now_ms;
    end
  end

endmodule

// ===== design/multichannel_button_debounce_to_notes.sv =====
// ----------------------------------------------------------------------------
// multichannel_button_debounce_to_notes
// Debounces sampled button levels per channel and emits note events.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_chan_index, in_level, in_now_ms
//  out     | output    | out_valid/out_stall| out_note, out_velocity, out_out_channel
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One word per cycle unless the result stalls; a word is taken into the input
//  register, then its decision is loaded into the result register.
//  The channel register file is read and updated in the same cycle, so
//  consecutive words on one channel see each other's updates.
//  Reset is synchronous; state is cleared at once, no clearing pass.
//  A stalled result holds the input register, which stalls the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multichannel_button_debounce_to_notes #(
  parameter int MAX_CHANNELS = mbdn_pkg::MAX_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [3:0]                      in_chan_index,
  input  logic                            in_level,
  input  logic [31:0]                     in_now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_note,
  output logic [6:0]                      out_velocity,
  output logic [3:0]                      out_out_channel,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbdn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbdn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mbdn_pkg::*;

  `include "multichannel_button_debounce_to_notes_assert.svh"

  cfg_t cfg;
  dec_t dec;

  logic        s1_valid_r;
  logic [3:0]  s1_chan_index_r;
  logic        s1_level_r;
  logic [31:0] s1_now_ms_r;

  logic       out_valid_r;
  logic [7:0] out_note_r;
  logic [6:0] out_velocity_r;
  logic [3:0] out_channel_r;

  logic out_free;
  logic advance;
  logic in_take;

  mbdn_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbdn_chan #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_chan (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .s1_valid      (s1_valid_r),
    .s1_chan_index (s1_chan_index_r),
    .s1_level      (s1_level_r),
    .s1_now_ms     (s1_now_ms_r),
    .advance       (advance),
    .dec           (dec)
  );

  // Flow control: result slot free, input register drains into it
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_chan_index_r <= in_chan_index;
      s1_level_r      <= in_level;
      s1_now_ms_r     <= in_now_ms;
    end
  end

  // Result register: load on a fired word, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && dec.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec.fire) begin
      out_note_r     <= dec.note;
      out_velocity_r <= dec.velocity;
      out_channel_r  <= cfg.midi_channel;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_note        = out_note_r;
  assign out_velocity    = out_velocity_r;
  assign out_out_channel = out_channel_r;

  `MBDN_ASSERT_NOW(a_stall_needs_word, in_stall, s1_valid_r)
  `MBDN_ASSERT_NEXT(a_fire_gives_result, advance && dec.fire,
                    out_valid_r && out_note_r == $past(dec.note))
  `MBDN_ASSERT_NEXT(a_no_fire_no_result, advance && !dec.fire, !out_valid_r)
  `MBDN_ASSERT_NOW(a_velocity_codes, out_valid_r,
                   out_velocity_r == VEL_PRESS || out_velocity_r == VEL_RELEASE)

endmodule

// ===== test/tb_multichannel_button_debounce_to_notes.sv =====
// ----------------------------------------------------------------------------
// tb_multichannel_button_debounce_to_notes
// Drives button samples with timestamps into the debounce block, predicts
// the note events from a per-channel level/time model and checks every
// event in order. Register settings change between phases while the block
// is idle; both sides pause at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multichannel_button_debounce_to_notes;
  import mbdn_pkg::*;

  localparam int NUM_CH        = MAX_CHANNELS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 125;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

  typedef struct packed {
    logic [7:0] note;
    logic [6:0] velocity;
    logic [3:0] chan;
  } note_evt_t;

  // One line of the directed plan: either a register setting or a sample
  typedef struct {
    bit          is_cfg;
    logic [15:0] deb;
    logic [15:0] first;
    logic [15:0] chan;
    logic [15:0] act;
    logic [3:0]  idx;
    logic        lvl;
    logic [31:0] now;
    bit          pinned;
    bit          fire;
    note_evt_t   evt;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [3:0] in_chan_index;
  logic in_level;
  logic [31:0] in_now_ms;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_note;
  logic [6:0] out_velocity;
  logic [3:0] out_out_channel;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Typed expectation travelling with a directed word
  logic pin_on;
  logic pin_fire;
  note_evt_t pin_evt;

  // Debounce state and settings as the block should hold them
  logic [15:0] deb_cfg;
  logic [6:0]  first_cfg;
  logic [3:0]  midi_cfg;
  logic [4:0]  act_cfg;
  logic        held_lvl [NUM_CH];
  logic [31:0] change_time [NUM_CH];

  note_evt_t note_q [$];
  int err_cnt;
  int sample_cnt;
  int note_cnt;
  int setting_cnt;
  int cycle_cnt;
  bit send_calm;
  bit recv_calm;

  multichannel_button_debounce_to_notes u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_chan_index   (in_chan_index),
    .in_level        (in_level),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_note        (out_note),
    .out_velocity    (out_velocity),
    .out_out_channel (out_out_channel),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Decide whether a sample is accepted as a new level; update the state
  function automatic bit debounce_note(input logic [3:0] ch_idx, input logic lvl,
                                       input logic [31:0] now, output note_evt_t evt);
    int unsigned span;
    logic [31:0] elapsed;
    evt = '0;
    span = (act_cfg > NUM_CH) ? NUM_CH : act_cfg;
    if (ch_idx >= span) return 1'b0;
    elapsed = now - change_time[ch_idx];
    if (elapsed <= {16'h0, deb_cfg}) return 1'b0;
    if (held_lvl[ch_idx] == lvl) return 1'b0;
    change_time[ch_idx] = now;
    held_lvl[ch_idx] = lvl;
    evt.note = {1'b0, first_cfg} + {4'h0, ch_idx};
    evt.velocity = (lvl == LEVEL_LOW) ? VEL_PRESS : VEL_RELEASE;
    evt.chan = midi_cfg;
    return 1'b1;
  endfunction

  function automatic int idle_draw(input bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic plan_row_t cfg_row(input logic [15:0] deb, input logic [15:0] first,
                                        input logic [15:0] chan, input logic [15:0] act);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.deb = deb;
    r.first = first;
    r.chan = chan;
    r.act = act;
    return r;
  endfunction

  function automatic plan_row_t sample_row(input logic [3:0] idx, input logic lvl,
                                           input logic [31:0] now);
    plan_row_t r;
    r = '{default: '0};
    r.idx = idx;
    r.lvl = lvl;
    r.now = now;
    return r;
  endfunction

  // Sample whose outcome is typed in: no event
  function automatic plan_row_t quiet_row(input logic [3:0] idx, input logic lvl,
                                          input logic [31:0] now);
    plan_row_t r;
    r = sample_row(idx, lvl, now);
    r.pinned = 1'b1;
    return r;
  endfunction

  // Sample whose outcome is typed in: one event
  function automatic plan_row_t event_row(input logic [3:0] idx, input logic lvl,
                                          input logic [31:0] now, input logic [7:0] note,
                                          input logic [6:0] vel, input logic [3:0] chan);
    plan_row_t r;
    r = quiet_row(idx, lvl, now);
    r.fire = 1'b1;
    r.evt.note = note;
    r.evt.velocity = vel;
    r.evt.chan = chan;
    return r;
  endfunction

  // Present one sample word and hold it until it is taken
  task automatic send_sample(input logic [3:0] idx, input logic lvl, input logic [31:0] now,
                             input bit pinned, input bit fire, input note_evt_t evt);
    int gap;
    gap = idle_draw(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_chan_index <= idx;
    in_level <= lvl;
    in_now_ms <= now;
    pin_on <= pinned;
    pin_fire <= fire;
    pin_evt <= evt;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending, wait for every pending event, then let the pipeline empty
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (note_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic reconfigure(input logic [15:0] deb, input logic [15:0] first,
                             input logic [15:0] chan, input logic [15:0] act);
    drain();
    write_reg(REG_DEBOUNCE_MS, deb);
    write_reg(REG_BASE_NOTE, first);
    write_reg(REG_MIDI_CHANNEL, chan);
    write_reg(REG_ACTIVE_CHANNELS, act);
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
    setting_cnt++;
  endtask

  // Predict on every accepted sample word and track register writes
  always @(posedge clk) begin : sample_mon
    note_evt_t evt;
    bit fire;
    if (rst_n && in_valid && !in_stall) begin
      fire = debounce_note(in_chan_index, in_level, in_now_ms, evt);
      if (pin_on) begin
        fire = pin_fire;
        evt = pin_evt;
      end
      if (fire) note_q.push_back(evt);
      sample_cnt++;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE_MS:     deb_cfg = cfg_data;
        REG_BASE_NOTE:       first_cfg = cfg_data[6:0];
        REG_MIDI_CHANNEL:    midi_cfg = cfg_data[3:0];
        REG_ACTIVE_CHANNELS: act_cfg = cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Compare each event word with the oldest prediction
  always @(posedge clk) begin : note_mon
    note_evt_t want;
    if (rst_n && out_valid && !out_stall) begin
      note_cnt++;
      if (note_q.size() == 0) begin
        $error("unexpected event: note %0d velocity %0d channel %0d",
               out_note, out_velocity, out_out_channel);
        err_cnt++;
      end else begin
        want = note_q.pop_front();
        if (out_note !== want.note) begin
          $error("note: expected %0d, got %0d", want.note, out_note);
          err_cnt++;
        end
        if (out_velocity !== want.velocity) begin
          $error("velocity: expected %0d, got %0d", want.velocity, out_velocity);
          err_cnt++;
        end
        if (out_out_channel !== want.chan) begin
          $error("out_channel: expected %0d, got %0d", want.chan, out_out_channel);
          err_cnt++;
        end
      end
    end
  end

  // Result side: stall a random number of cycles before each event
  initial begin : event_sink
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = idle_draw(recv_calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("multichannel_button_debounce_to_notes: mismatch");
      $finish;
    end
  end

  initial begin : stim
    plan_row_t plan [$];
    logic        lvl_want [NUM_CH];
    logic [31:0] ch_clock [NUM_CH];
    logic [15:0] deb;
    logic [15:0] first;
    logic [15:0] act;
    logic [4:0]  act5;
    logic [31:0] step;
    logic [31:0] now;
    logic [3:0]  ch;
    logic        lvl;
    int unsigned span;
    int counted;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_chan_index <= '0;
    in_level <= 1'b0;
    in_now_ms <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    pin_on <= 1'b0;
    pin_fire <= 1'b0;
    pin_evt <= '0;
    err_cnt = 0;
    sample_cnt = 0;
    note_cnt = 0;
    setting_cnt = 0;
    cycle_cnt = 0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    deb_cfg = DEBOUNCE_RST;
    first_cfg = BASE_NOTE_RST;
    midi_cfg = MIDI_CHANNEL_RST;
    act_cfg = ACTIVE_RST;
    for (int k = 0; k < NUM_CH; k++) begin
      held_lvl[k] = LEVEL_LOW;
      change_time[k] = '0;
      lvl_want[k] = LEVEL_LOW;
      ch_clock[k] = '0;
    end

    // Reset settings: unchanged level, lockout edge, wrap in both directions
    plan.push_back(quiet_row(4'd0, 1'b0, 32'd1000));
    plan.push_back(event_row(4'd0, 1'b1, 32'd1000, 8'd36, VEL_RELEASE, 4'd0));
    plan.push_back(quiet_row(4'd0, 1'b0, 32'd1050));
    plan.push_back(event_row(4'd0, 1'b0, 32'd1051, 8'd36, VEL_PRESS, 4'd0));
    plan.push_back(event_row(4'd15, 1'b1, 32'hFFFF_FFFF, 8'd51, VEL_RELEASE, 4'd0));
    plan.push_back(quiet_row(4'd15, 1'b0, 32'd5));
    plan.push_back(event_row(4'd15, 1'b0, 32'd50, 8'd51, VEL_PRESS, 4'd0));
    plan.push_back(quiet_row(4'd7, 1'b1, 32'd0));
    plan.push_back(event_row(4'd7, 1'b1, 32'd51, 8'd43, VEL_RELEASE, 4'd0));
    plan.push_back(quiet_row(4'd7, 1'b1, 32'd16));
    plan.push_back(event_row(4'd7, 1'b0, 32'd40, 8'd43, VEL_PRESS, 4'd0));
    // No lockout, top note, one channel in use
    plan.push_back(cfg_row(16'd0, 16'd127, 16'd15, 16'd1));
    plan.push_back(quiet_row(4'd1, 1'b1, 32'd100000));
    plan.push_back(event_row(4'd0, 1'b1, 32'd1052, 8'd127, VEL_RELEASE, 4'd15));
    plan.push_back(quiet_row(4'd0, 1'b0, 32'd1052));
    plan.push_back(quiet_row(4'd15, 1'b1, 32'h8000_0000));
    // Longest lockout; count of 31 acts as all channels
    plan.push_back(cfg_row(16'hFFFF, 16'hFF80, 16'hFFF3, 16'h003F));
    plan.push_back(quiet_row(4'd15, 1'b1, 32'd65585));
    plan.push_back(event_row(4'd15, 1'b1, 32'd65586, 8'd15, VEL_RELEASE, 4'd3));
    plan.push_back(event_row(4'd3, 1'b1, 32'hFFFF_FFFF, 8'd3, VEL_RELEASE, 4'd3));
    // Channel count of zero: everything ignored
    plan.push_back(cfg_row(16'd0, 16'h007F, 16'h0010, 16'hFFE0));
    plan.push_back(quiet_row(4'd0, 1'b0, 32'd2000));
    plan.push_back(quiet_row(4'd15, 1'b0, 32'd0));
    plan.push_back(cfg_row(16'd1, 16'd0, 16'd0, 16'd16));
    plan.push_back(event_row(4'd8, 1'b1, 32'd2, 8'd8, VEL_RELEASE, 4'd0));
    plan.push_back(quiet_row(4'd8, 1'b0, 32'd3));
    plan.push_back(sample_row(4'd5, 1'b1, 32'h1234_5678));
    plan.push_back(sample_row(4'd9, 1'b1, 32'hDEAD_BEEF));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed plan
    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        reconfigure(plan[i].deb, plan[i].first, plan[i].chan, plan[i].act);
      else
        send_sample(plan[i].idx, plan[i].lvl, plan[i].now, plan[i].pinned,
                    plan[i].fire, plan[i].evt);
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin deb = 16'd0;    first = 16'h007F; act5 = 5'd16; end
        1: begin deb = 16'hFFFF; first = 16'h0000; act5 = 5'd1;  end
        2: begin deb = 16'($urandom_range(0, 200)); first = 16'($urandom); act5 = 5'd31; end
        default: begin
          deb = $urandom_range(0, 1) ? 16'($urandom_range(0, 200)) : 16'($urandom);
          first = 16'($urandom);
          act5 = 5'($urandom_range(1, 31));
        end
      endcase
      act = 16'($urandom);
      act[4:0] = act5;
      reconfigure(deb, first, 16'($urandom), act);
      send_calm = (p % 4 == 1) || (p == 6);
      recv_calm = (p % 4 == 2) || (p == 6);
      span = (act5 > NUM_CH) ? NUM_CH : act5;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          // Mostly toggling presses timed around the lockout edge
          ch = 4'($urandom_range(0, span - 1));
          case ($urandom_range(0, 5))
            0:       step = $urandom_range(0, 3);
            1, 2:    step = {16'h0, deb} + $urandom_range(0, 3) - 1;
            3:       step = {16'h0, deb} + $urandom_range(1, 2000);
            4:       step = $urandom;
            default: step = 32'd0 - $urandom_range(1, 100);
          endcase
          ch_clock[ch] = ch_clock[ch] + step;
          if ($urandom_range(0, 3) != 0) lvl_want[ch] = ~lvl_want[ch];
          lvl = lvl_want[ch];
          now = ch_clock[ch];
        end else begin
          ch = 4'($urandom_range(0, 15));
          lvl = 1'($urandom);
          now = $urandom;
        end
        send_sample(ch, lvl, now, 1'b0, 1'b0, '0);
        if (ch < span) counted++;
        // Now and then hold off until the result side has caught up
        if ($urandom_range(0, 99) == 0) drain();
      end
    end

    drain();
    $display("%0d samples accepted, %0d note events checked, %0d register settings",
             sample_cnt, note_cnt, setting_cnt);
    $display("covered lockout edges, timestamp wrap, unchanged levels and idle channels");
    if (err_cnt == 0 && note_q.size() == 0) begin
      $display("multichannel_button_debounce_to_notes: match");
    end else begin
      $display("multichannel_button_debounce_to_notes: mismatch");
    end
    $finish;
  end

endmodule
